>>> hdl/wrsi_pkg.sv
// Package with the shared types and constants of the Wilder RSI indicator.
package wrsi_pkg;

  // Fixed field widths.
  localparam int unsigned PERIOD_W     = 7;
  localparam int unsigned PERIOD_RESET = 14;
  localparam int unsigned AVG_W        = 48;
  localparam int unsigned RSI_W        = 14;

  // RSI scale: results are in hundredths of a percent point.
  localparam int unsigned RSI_SCALE = 100;
  localparam int unsigned RSI_FULL  = RSI_SCALE * RSI_SCALE;
  localparam int unsigned RSI_HALF  = RSI_FULL / 2;

  // Shared multiplier and divider widths.
  localparam int unsigned MULB_W = RSI_W;
  localparam int unsigned PROD_W = AVG_W + MULB_W;
  localparam int unsigned DVS_W  = AVG_W + 1;
  localparam int unsigned REM_W  = DVS_W + 1;
  localparam int unsigned QCNT_W = $clog2(AVG_W + 1);

  // Parameter defaults for the top level.
  localparam int unsigned DEF_MAX_PERIOD    = 64;
  localparam int unsigned DEF_PRICE_BITS    = 32;
  localparam int unsigned DEF_FRACTION_BITS = 16;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL,
    ST_DIVGO,
    ST_DIVWAIT,
    ST_RSI,
    ST_RDIV,
    ST_RWAIT,
    ST_OUT
  } wrsi_state_e;

  // Divider request and response.
  typedef struct packed {
    logic go;
    logic rsi_mode;
  } wrsi_div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } wrsi_div_rsp_t;

endpackage

>>> hdl/wrsi_div.sv
// Restoring divider, one quotient bit per cycle, shared by smoothing and RSI.
module wrsi_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  wrsi_pkg::wrsi_div_req_t           req_i,
  input  logic [wrsi_pkg::PROD_W-1:0]       dividend_i,
  input  logic [wrsi_pkg::DVS_W-1:0]        divisor_i,
  output wrsi_pkg::wrsi_div_rsp_t           rsp_o,
  output logic [wrsi_pkg::AVG_W-1:0]        quotient_o
);

  localparam int unsigned QW = wrsi_pkg::AVG_W;
  localparam int unsigned SQ = wrsi_pkg::RSI_W;

  logic [wrsi_pkg::REM_W-1:0]  rem_q, rem_d;
  logic [QW-1:0]               dvd_q, dvd_d;
  logic [QW-1:0]               quo_q, quo_d;
  logic [wrsi_pkg::DVS_W-1:0]  dvs_q, dvs_d;
  logic [wrsi_pkg::QCNT_W-1:0] cnt_q, cnt_d;
  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic [wrsi_pkg::REM_W-1:0]  trial;
  logic                        fits;

  // One restoring step: shift in the next dividend bit and try to subtract.
  always_comb begin
    trial = {rem_q[wrsi_pkg::REM_W-2:0], dvd_q[QW-1]};
    fits  = trial >= {1'b0, dvs_q};
  end

  // Load on a request; the quotient is known to fit the selected width,
  // so the dividend bits above it seed the remainder directly.
  always_comb begin
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.go) begin
      dvs_d  = divisor_i;
      quo_d  = '0;
      busy_d = 1'b1;
      if (req_i.rsi_mode) begin
        rem_d = wrsi_pkg::REM_W'(dividend_i >> SQ);
        dvd_d = QW'(dividend_i[SQ-1:0]) << (QW - SQ);
        cnt_d = wrsi_pkg::QCNT_W'(SQ);
      end else begin
        rem_d = wrsi_pkg::REM_W'(dividend_i >> QW);
        dvd_d = dividend_i[QW-1:0];
        cnt_d = wrsi_pkg::QCNT_W'(QW);
      end
    end else if (busy_q) begin
      rem_d = fits ? (trial - {1'b0, dvs_q}) : trial;
      dvd_d = dvd_q << 1;
      quo_d = {quo_q[QW-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == wrsi_pkg::QCNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign quotient_o = quo_q;

endmodule

>>> hdl/wilder_rsi_indicator.sv
// Top level of the Wilder-smoothed relative strength index unit.
//
//  Channel   Direction  Contents (lowest bit first)
//  s_axis    in         tdata: close_price; tuser: start_series
//  m_axis    out        tdata: rsi_hundredths, average_gain, average_loss, pad;
//                       tuser: rsi_valid
//  cfg       in         period, written when cfg_wen_i is high
//
// One price is worked on at a time; s_axis_tready is high only while idle.
// A smoothing step runs from acceptance to a valid result as follows:
// each average needs a multiply and a full-width pass of the shared
// divider, then the RSI ratio needs a multiply and an RSI-mode divider pass.
// A first price or a not-yet-valid step does not use the divider; the step that
// closes the seeding window runs the divider for both sums as well.
// A result waits in the output register until taken; reset clears the series.
module wilder_rsi_indicator #(
  parameter int unsigned MAX_PERIOD    = wrsi_pkg::DEF_MAX_PERIOD,
  parameter int unsigned PRICE_BITS    = wrsi_pkg::DEF_PRICE_BITS,
  parameter int unsigned FRACTION_BITS = wrsi_pkg::DEF_FRACTION_BITS
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // tdata: close_price [PRICE_BITS-1:0], zero pad to whole bytes.
  input  logic [((PRICE_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
  // tuser: start_series.
  input  logic                                   s_axis_tuser,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // tdata: rsi_hundredths [13:0], average_gain [61:14], average_loss [109:62],
  // zero pad [111:110].
  output logic [111:0]                           m_axis_tdata,
  // tuser: rsi_valid.
  output logic                                   m_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  input  logic                                   cfg_wen_i,
  input  logic [wrsi_pkg::PERIOD_W-1:0]          cfg_wdata_i
);

  localparam int unsigned NW = $clog2(MAX_PERIOD + 1);
  localparam int unsigned SW = $clog2(MAX_PERIOD + 2);
  localparam int unsigned AW = wrsi_pkg::AVG_W;
  localparam int unsigned OUT_W = 2 * AW + wrsi_pkg::RSI_W;

  wrsi_pkg::wrsi_state_e state_q, state_d;

  logic [wrsi_pkg::PERIOD_W-1:0] period_q;
  logic [PRICE_BITS-1:0]         last_q, price_q;
  logic [SW-1:0]                 seen_q;
  logic [AW-1:0]                 gain_q, loss_q;
  logic                          start_q;
  logic [NW-1:0]                 n_q, n_win;
  logic [AW-1:0]                 gmv_q, lmv_q, gmv, lmv;
  logic [wrsi_pkg::PROD_W-1:0]   prod_q;
  logic                          sel_q, smooth_q;
  logic [wrsi_pkg::RSI_W-1:0]    rsi_q;
  logic                          valid_q;

  logic [SW-1:0]                 prior_cnt, n_ext;
  logic                          first_px, seeding, seed_end, rsi_ok;
  logic [AW-1:0]                 cur_avg, cur_move;
  logic [AW-1:0]                 mul_a;
  logic [wrsi_pkg::MULB_W-1:0]   mul_b;
  logic [AW:0]                   gsum, lsum;
  logic [PRICE_BITS-1:0]         diff;
  logic [AW-1:0]                 diff_ext, move_fx;

  wrsi_pkg::wrsi_div_req_t       div_req;
  wrsi_pkg::wrsi_div_rsp_t       div_rsp;
  logic [wrsi_pkg::PROD_W-1:0]   div_dvd;
  logic [wrsi_pkg::DVS_W-1:0]    div_dvs;
  logic [AW-1:0]                 div_quo;

  // Averaging window, clamped to the supported range.
  always_comb begin
    if (int'(period_q) < 2) begin
      n_win = NW'(2);
    end else if (int'(period_q) > int'(MAX_PERIOD)) begin
      n_win = NW'(MAX_PERIOD);
    end else begin
      n_win = NW'(period_q);
    end
  end

  // Price move as a fixed-point value, saturating at the average width.
  always_comb begin
    diff     = (price_q > last_q) ? (price_q - last_q) : (last_q - price_q);
    diff_ext = AW'(diff);
    if ((diff_ext >> (AW - FRACTION_BITS)) != '0) begin
      move_fx = '1;
    end else begin
      move_fx = diff_ext << FRACTION_BITS;
    end
    gmv = (price_q > last_q) ? move_fx : '0;
    lmv = (price_q > last_q) ? '0 : move_fx;
  end

  // Series bookkeeping decoded from the count of prices seen.
  always_comb begin
    n_ext     = SW'(n_q);
    prior_cnt = seen_q - 1'b1;
    first_px  = start_q || (seen_q == '0);
    seeding   = prior_cnt < n_ext;
    seed_end  = prior_cnt == (n_ext - 1'b1);
    rsi_ok    = (seen_q != '0) && ((seen_q - 1'b1) >= n_ext);
    gsum      = {1'b0, gain_q} + {1'b0, gmv};
    lsum      = {1'b0, loss_q} + {1'b0, lmv};
    cur_avg   = sel_q ? loss_q : gain_q;
    cur_move  = sel_q ? lmv_q : gmv_q;
  end

  // Shared multiplier operands: window minus one when smoothing, full scale for RSI.
  always_comb begin
    if (state_q == wrsi_pkg::ST_RSI) begin
      mul_a = gain_q;
      mul_b = wrsi_pkg::MULB_W'(wrsi_pkg::RSI_FULL);
    end else begin
      mul_a = cur_avg;
      mul_b = wrsi_pkg::MULB_W'(n_q - 1'b1);
    end
  end

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      wrsi_pkg::ST_IDLE: begin
        if (s_axis_tvalid) state_d = wrsi_pkg::ST_PREP;
      end
      wrsi_pkg::ST_PREP: begin
        if (first_px) begin
          state_d = wrsi_pkg::ST_RSI;
        end else if (!seeding) begin
          state_d = wrsi_pkg::ST_MUL;
        end else if (seed_end) begin
          state_d = wrsi_pkg::ST_DIVGO;
        end else begin
          state_d = wrsi_pkg::ST_RSI;
        end
      end
      wrsi_pkg::ST_MUL:    state_d = wrsi_pkg::ST_DIVGO;
      wrsi_pkg::ST_DIVGO:  state_d = wrsi_pkg::ST_DIVWAIT;
      wrsi_pkg::ST_DIVWAIT: begin
        if (div_rsp.done) begin
          if (sel_q) begin
            state_d = wrsi_pkg::ST_RSI;
          end else begin
            state_d = smooth_q ? wrsi_pkg::ST_MUL : wrsi_pkg::ST_DIVGO;
          end
        end
      end
      wrsi_pkg::ST_RSI: begin
        if (rsi_ok && (loss_q != '0)) begin
          state_d = wrsi_pkg::ST_RDIV;
        end else begin
          state_d = wrsi_pkg::ST_OUT;
        end
      end
      wrsi_pkg::ST_RDIV:  state_d = wrsi_pkg::ST_RWAIT;
      wrsi_pkg::ST_RWAIT: begin
        if (div_rsp.done) state_d = wrsi_pkg::ST_OUT;
      end
      wrsi_pkg::ST_OUT: begin
        if (m_axis_tready) state_d = wrsi_pkg::ST_IDLE;
      end
      default: state_d = wrsi_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: handshakes and divider requests.
  always_comb begin
    s_axis_tready    = 1'b0;
    m_axis_tvalid    = 1'b0;
    div_req.go       = 1'b0;
    div_req.rsi_mode = 1'b0;
    div_dvd          = prod_q + wrsi_pkg::PROD_W'(cur_move);
    div_dvs          = wrsi_pkg::DVS_W'(n_q);
    case (state_q)
      wrsi_pkg::ST_IDLE: s_axis_tready = 1'b1;
      wrsi_pkg::ST_DIVGO: begin
        div_req.go = 1'b1;
        if (!smooth_q) div_dvd = wrsi_pkg::PROD_W'(cur_avg);
      end
      wrsi_pkg::ST_RDIV: begin
        div_req.go       = 1'b1;
        div_req.rsi_mode = 1'b1;
        div_dvd          = prod_q;
        div_dvs          = wrsi_pkg::DVS_W'(gain_q) + wrsi_pkg::DVS_W'(loss_q);
      end
      wrsi_pkg::ST_OUT: m_axis_tvalid = 1'b1;
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wrsi_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Period register and series state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= wrsi_pkg::PERIOD_W'(wrsi_pkg::PERIOD_RESET);
      last_q   <= '0;
      seen_q   <= '0;
      gain_q   <= '0;
      loss_q   <= '0;
      sel_q    <= 1'b0;
    end else begin
      if (cfg_wen_i) period_q <= cfg_wdata_i;
      case (state_q)
        wrsi_pkg::ST_PREP: begin
          last_q <= price_q;
          sel_q  <= 1'b0;
          if (first_px) begin
            seen_q <= SW'(1);
            gain_q <= '0;
            loss_q <= '0;
          end else begin
            if (seen_q < SW'(MAX_PERIOD + 1)) seen_q <= seen_q + 1'b1;
            if (seeding) begin
              gain_q <= gsum[AW] ? '1 : gsum[AW-1:0];
              loss_q <= lsum[AW] ? '1 : lsum[AW-1:0];
            end
          end
        end
        wrsi_pkg::ST_DIVWAIT: begin
          if (div_rsp.done) begin
            if (sel_q) begin
              loss_q <= div_quo;
            end else begin
              gain_q <= div_quo;
            end
            sel_q <= 1'b1;
          end
        end
        default: begin
          sel_q <= sel_q;
        end
      endcase
    end
  end

  // Payload registers: accepted item, moves, product and result.
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      price_q <= s_axis_tdata[PRICE_BITS-1:0];
      start_q <= s_axis_tuser;
      n_q     <= n_win;
    end
    if (state_q == wrsi_pkg::ST_PREP) begin
      gmv_q    <= gmv;
      lmv_q    <= lmv;
      smooth_q <= !seeding;
    end
    if ((state_q == wrsi_pkg::ST_MUL) || (state_q == wrsi_pkg::ST_RSI)) begin
      prod_q <= wrsi_pkg::PROD_W'(mul_a) * wrsi_pkg::PROD_W'(mul_b);
    end
    if (state_q == wrsi_pkg::ST_RSI) begin
      valid_q <= rsi_ok;
      if (!rsi_ok) begin
        rsi_q <= '0;
      end else if ((gain_q == '0) && (loss_q == '0)) begin
        rsi_q <= wrsi_pkg::RSI_W'(wrsi_pkg::RSI_HALF);
      end else begin
        rsi_q <= wrsi_pkg::RSI_W'(wrsi_pkg::RSI_FULL);
      end
    end
    if ((state_q == wrsi_pkg::ST_RWAIT) && div_rsp.done) begin
      rsi_q <= div_quo[wrsi_pkg::RSI_W-1:0];
    end
  end

  wrsi_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .rsp_o      (div_rsp),
    .quotient_o (div_quo)
  );

  // Result transaction; averages read as zero until the window is filled.
  assign m_axis_tdata = {{(112 - OUT_W){1'b0}},
                         (valid_q ? loss_q : {AW{1'b0}}),
                         (valid_q ? gain_q : {AW{1'b0}}),
                         rsi_q};
  assign m_axis_tuser = valid_q;

  // The input side is never open while a result is on offer.
  a_excl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while a result is pending");

  // An offered RSI never exceeds full scale.
  a_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[wrsi_pkg::RSI_W-1:0] <=
                       wrsi_pkg::RSI_W'(wrsi_pkg::RSI_FULL)))
    else $error("RSI above full scale");

  // A result flagged not valid carries all-zero data.
  a_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("non-valid result carries data");

  // The divider only finishes while the sequencer waits for it.
  a_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> ((state_q == wrsi_pkg::ST_DIVWAIT) ||
                      (state_q == wrsi_pkg::ST_RWAIT)))
    else $error("divider finished outside a wait state");

  // A new division is only started once the previous one has finished.
  a_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.go |-> !div_rsp.busy)
    else $error("divider started while busy");

endmodule
